// ----- src/minimal_standard_lcg_bounded_draw_defines.svh -----
// Assertion macros used by the bounded draw generator back end.
`ifndef MINIMAL_STANDARD_LCG_BOUNDED_DRAW_DEFINES_SVH
`define MINIMAL_STANDARD_LCG_BOUNDED_DRAW_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define LCGBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define LCGBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lcgbd_pkg.sv -----
// Types and constants of the minimal standard generator with bounded draws.
`timescale 1ns / 1ps
`default_nettype none
package lcgbd_pkg;

  localparam int unsigned LCGBD_QUEUE_DEPTH = 2;

  localparam int unsigned STATE_W     = 31;
  localparam int unsigned BOUND_W     = 32;
  localparam int unsigned SEED_W      = 31;
  localparam int unsigned VALUE_W     = 31;
  localparam int unsigned MULT_W      = 15;
  localparam int unsigned PROD_W      = STATE_W + MULT_W;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned DIV_STEPS   = STATE_W;

  localparam logic [MULT_W-1:0]  LCG_MULT    = 15'd16807;
  localparam logic [STATE_W-1:0] LCG_MODULUS = 31'h7FFF_FFFF;
  localparam logic [STATE_W-1:0] LCG_MASK    = 31'd123459876;

  typedef enum logic {
    REQ_DRAW = 1'b0,
    REQ_SEED = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_ZERO = 2'd1,
    OP_SEED = 2'd2
  } op_e;

  // Draw: operand is the positive bound. Reseed: operand is the new state.
  typedef struct packed {
    op_e                op;
    logic [STATE_W-1:0] operand;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/lcgbd_front.sv -----
// Front end: classifies incoming items and forms the command for the queue.
`timescale 1ns / 1ps
`default_nettype none
module lcgbd_front (
  input  wire logic                               s_tvalid_i,
  output logic                                    s_tready_o,
  input  wire logic [lcgbd_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  input  wire logic                               s_tuser_i,
  input  wire logic                               full_i,
  output logic                                    push_o,
  output lcgbd_pkg::cmd_t                         cmd_o
);
  import lcgbd_pkg::*;

  logic [BOUND_W-1:0] bound;
  logic [SEED_W-1:0]  seed;
  logic [SEED_W-1:0]  seed_eff;

  assign bound = s_tdata_i[BOUND_W-1:0];
  assign seed  = s_tdata_i[BOUND_W+SEED_W-1:BOUND_W];

  // A seed equal to the mask would give an all-zero state, so it maps to zero first.
  assign seed_eff = (seed == LCG_MASK) ? '0 : seed;

  assign s_tready_o = !full_i;
  assign push_o     = s_tvalid_i && !full_i;

  always_comb begin
    if (s_tuser_i == REQ_SEED) begin
      cmd_o.op      = OP_SEED;
      cmd_o.operand = seed_eff ^ LCG_MASK;
    end else if (!bound[BOUND_W-1] && (bound != '0)) begin
      cmd_o.op      = OP_DRAW;
      cmd_o.operand = bound[STATE_W-1:0];
    end else begin
      cmd_o.op      = OP_ZERO;
      cmd_o.operand = '0;
    end
  end

endmodule
`default_nettype wire

// ----- src/lcgbd_fifo.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module lcgbd_fifo #(
  parameter int unsigned Depth = lcgbd_pkg::LCGBD_QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lcgbd_pkg::cmd_t cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output lcgbd_pkg::cmd_t      cmd_o
);
  import lcgbd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ----- src/lcgbd_back.sv -----
// Back end: generator state, state advance, remainder by the bound and the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "minimal_standard_lcg_bounded_draw_defines.svh"
module lcgbd_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                empty_i,
  input  wire lcgbd_pkg::cmd_t                     cmd_i,
  output logic                                     pop_o,
  output logic                                     m_tvalid_o,
  input  wire logic                                m_tready_i,
  output logic [lcgbd_pkg::OUT_TDATA_W-1:0]        m_tdata_o
);
  import lcgbd_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_FOLD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } fsm_e;

  fsm_e               fsm_q, fsm_d;
  logic [STATE_W-1:0] state_q, state_d;
  logic [STATE_W-1:0] bound_q, bound_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [STATE_W-1:0] dvd_q, dvd_d;
  logic [STATE_W-1:0] rem_q, rem_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_data_q, out_data_d;

  logic               out_free;
  logic [STATE_W:0]   fold_sum;
  logic [STATE_W:0]   fold_sub;
  logic [STATE_W-1:0] fold_res;
  logic [STATE_W:0]   trial;
  logic [STATE_W:0]   trial_sub;
  logic               trial_ge;

  assign out_free = !out_valid_q || m_tready_i;

  // 2^31 is 1 modulo 2^31-1, so the high part of the product folds onto the low part.
  assign fold_sum = {1'b0, prod_q[STATE_W-1:0]} + (STATE_W + 1)'(prod_q[PROD_W-1:STATE_W]);
  assign fold_sub = fold_sum - {1'b0, LCG_MODULUS};
  assign fold_res = (fold_sum >= {1'b0, LCG_MODULUS}) ? fold_sub[STATE_W-1:0]
                                                      : fold_sum[STATE_W-1:0];

  // One restoring division step; the partial remainder always stays below the bound.
  assign trial     = {rem_q, dvd_q[STATE_W-1]};
  assign trial_sub = trial - {1'b0, bound_q};
  assign trial_ge  = (trial >= {1'b0, bound_q});

  always_comb begin
    fsm_d       = fsm_q;
    state_d     = state_q;
    bound_d     = bound_q;
    prod_d      = prod_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    case (fsm_q)
      S_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.op)
            OP_DRAW: begin
              pop_o   = 1'b1;
              bound_d = cmd_i.operand;
              fsm_d   = S_MUL;
            end
            OP_ZERO: begin
              if (out_free) begin
                pop_o       = 1'b1;
                out_valid_d = 1'b1;
                out_data_d  = '0;
              end
            end
            OP_SEED: begin
              if (out_free) begin
                pop_o       = 1'b1;
                state_d     = cmd_i.operand;
                out_valid_d = 1'b1;
                out_data_d  = '0;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        prod_d = PROD_W'(LCG_MULT) * PROD_W'(state_q);
        fsm_d  = S_FOLD;
      end
      S_FOLD: begin
        state_d = fold_res;
        dvd_d   = fold_res;
        rem_d   = '0;
        cnt_d   = '0;
        fsm_d   = S_DIV;
      end
      S_DIV: begin
        rem_d = trial_ge ? trial_sub[STATE_W-1:0] : trial[STATE_W-1:0];
        dvd_d = {dvd_q[STATE_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_STEPS - 1)) begin
          fsm_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = rem_q;
          fsm_d       = S_IDLE;
        end
      end
      default: begin
        fsm_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      state_q     <= LCG_MASK;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q    <= bound_d;
    prod_q     <= prod_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = OUT_TDATA_W'(out_data_q);

  `LCGBD_ASSERT_NEXT(a_state_reduced, fsm_q == S_FOLD, state_q != LCG_MODULUS, "state not reduced")
  `LCGBD_ASSERT_SAME(a_rem_below_bound, fsm_q == S_DIV, rem_q < bound_q, "remainder above bound")
  `LCGBD_ASSERT_SAME(a_cnt_range, fsm_q == S_DIV, cnt_q < CntW'(DIV_STEPS), "step count overrun")
  `LCGBD_ASSERT_NEXT(a_draw_start, pop_o && (cmd_i.op == OP_DRAW), fsm_q == S_MUL, "draw not started")

endmodule
`default_nettype wire

// ----- src/minimal_standard_lcg_bounded_draw.sv -----
// Top level of the minimal standard generator with bounded draws.
//
// Input channel s_axis: tuser selects the request (0 = draw, 1 = reseed),
// tdata carries the signed bound in bits 31:0 and the seed in bits 62:32.
// Output channel m_axis: tdata bits 30:0 hold the value; one item per request.
// A draw with a positive bound advances the state to 16807 * state mod (2^31-1)
// and returns the new state modulo the bound. A draw with a bound of zero or
// below, and a reseed, return 0.
// Items enter a short command queue; the back end takes one command at a time.
// A positive draw runs through the back end in order: one multiply, one reduction,
// 31 restoring division steps and one output load, and the back end takes no new
// command until the draw is done. Zero draws and reseeds load the output
// register straight from the idle state when it is free.
// Reset empties the queue and loads the state with 123459876.
// When the receiver stalls, the output register holds its item, the back end
// waits, and the queue keeps taking items until it is full.
`timescale 1ns / 1ps
`default_nettype none
module minimal_standard_lcg_bounded_draw #(
  parameter int unsigned QueueDepth = lcgbd_pkg::LCGBD_QUEUE_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // bound [31:0], seed [62:32], zero [63]
  input  wire logic [lcgbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // req_type [0]
  input  wire logic [0:0]                         s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // value [30:0], zero [31]
  output logic [lcgbd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o
);
  import lcgbd_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t cmd_in;
  cmd_t cmd_out;

  lcgbd_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i[0]),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  lcgbd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  lcgbd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .cmd_i      (cmd_out),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the bounded draw generator: draw predictor, stream drivers and checks.
module tb_top;
  import lcgbd_pkg::*;

  localparam logic [30:0] MODULUS     = 31'h7FFF_FFFF;
  localparam logic [30:0] SEED_MASK   = 31'd123459876;
  localparam int unsigned MULTIPLIER  = 16807;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned DRAIN_WAIT  = 50;

  // Tracks the generator state and holds the values still owed by the block.
  class lcg_scoreboard;
    logic [30:0] gen_state;
    logic [30:0] expected_values[$];
    int unsigned errors;

    function new();
      gen_state = SEED_MASK;
      errors    = 0;
    endfunction

    function logic [30:0] next_state(logic [30:0] cur);
      logic [63:0] prod;
      prod = 64'(cur) * 64'(MULTIPLIER);
      return 31'(prod % 64'(MODULUS));
    endfunction

    function void note_request(req_e kind, logic [31:0] bound, logic [30:0] seed);
      logic [30:0] value;
      logic [30:0] folded;
      value = '0;
      if (kind == REQ_SEED) begin
        // A seed equal to the mask would give state zero, so it is folded to zero first.
        folded    = (seed == SEED_MASK) ? '0 : seed;
        gen_state = folded ^ SEED_MASK;
      end else if (!bound[31] && bound != '0) begin
        gen_state = next_state(gen_state);
        value     = 31'({1'b0, gen_state} % bound);
      end
      expected_values.push_back(value);
    endfunction

    function void check_value(logic [31:0] tdata);
      logic [31:0] want;
      if (expected_values.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, tdata);
        return;
      end
      want = {1'b0, expected_values.pop_front()};
      if (tdata[30:0] !== want[30:0]) begin
        errors++;
        $display("%0t: value mismatch, expected %h, actual %h", $time, want[30:0],
                 tdata[30:0]);
      end
      if (tdata[31] !== 1'b0) begin
        errors++;
        $display("%0t: padding bit mismatch, expected 0, actual %b", $time, tdata[31]);
      end
    endfunction

    function int unsigned pending();
      return expected_values.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  wire                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i;
  logic [0:0]            s_axis_tuser_i;
  wire                   m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  wire [OUT_TDATA_W-1:0] m_axis_tdata_o;

  lcg_scoreboard board = new();
  bit            quiet_phase;

  minimal_standard_lcg_bounded_draw dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no pause, some short ones and now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [31:0] pick_bound();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'd0;
    if (r < 10) return 32'h8000_0000 | 32'($urandom);
    if (r < 30) return 32'($urandom_range(1, 16));
    if (r < 55) return {1'b0, 31'($urandom)};
    if (r < 70) return 32'd1 << $urandom_range(0, 30);
    return 32'($urandom_range(1, $urandom_range(1, 32'h7FFF_FFFF)));
  endfunction

  function automatic logic [30:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return SEED_MASK;
      1: return SEED_MASK ^ 31'h7FFF_FFFF;
      2: return 31'h7FFF_FFFF;
      3: return '0;
      default: return 31'($urandom);
    endcase
  endfunction

  // Holds valid high across back-to-back items; lowers it only when a gap is due.
  task automatic send_item(req_e kind, logic [31:0] bound, logic [30:0] seed);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {1'b0, seed, bound};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(kind, bound, seed);
  endtask

  task automatic send_random();
    if ($urandom_range(0, 99) < 12)
      send_item(REQ_SEED, 32'($urandom), pick_seed());
    else
      send_item(REQ_DRAW, pick_bound(), 31'($urandom));
  endtask

  initial begin
    quiet_phase = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= REQ_DRAW;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes and the ignored fields carrying nonzero bits.
    send_item(REQ_DRAW, 32'd1, 31'h7FFF_FFFF);
    send_item(REQ_DRAW, 32'h7FFF_FFFF, '0);
    send_item(REQ_DRAW, 32'd0, '0);
    send_item(REQ_DRAW, 32'hFFFF_FFFF, '0);
    send_item(REQ_DRAW, 32'h8000_0000, 31'h7FFF_FFFF);
    send_item(REQ_DRAW, 32'd2, '0);
    send_item(REQ_DRAW, 32'd16807, '0);
    send_item(REQ_SEED, 32'hFFFF_FFFF, '0);
    send_item(REQ_DRAW, 32'd1000, '0);
    // A seed equal to the mask is folded to zero before the XOR.
    send_item(REQ_SEED, '0, SEED_MASK);
    send_item(REQ_DRAW, 32'h7FFF_FFFF, '0);
    // State at the modulus collapses to zero and stays there until a reseed.
    send_item(REQ_SEED, '0, SEED_MASK ^ 31'h7FFF_FFFF);
    send_item(REQ_DRAW, 32'd0, '0);
    send_item(REQ_DRAW, 32'h7FFF_FFFF, '0);
    send_item(REQ_DRAW, 32'd5, '0);
    send_item(REQ_DRAW, 32'd1, '0);
    send_item(REQ_SEED, '0, 31'h7FFF_FFFF);
    send_item(REQ_DRAW, 32'd3, '0);
    send_item(REQ_SEED, '0, 31'h5555_5555);
    send_item(REQ_DRAW, 32'h4000_0000, '0);

    // Some phases run with no pauses on either side.
    for (int unsigned p = 0; p < PHASES; p++) begin
      quiet_phase = (p == 2) || (p == 5);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) send_random();
    end
    s_axis_tvalid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Result side: checks each accepted item, then decides whether to stall.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) board.check_value(m_axis_tdata_o);
      if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
